>>> rtl/core/sit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the sorted insert table: transaction payload types, action and
// status codes, and the control bundle handed from the top level to each cell.

package sit_pkg;

    // Action codes of a command transaction
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // Status codes of a response transaction
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_RANGE_ERR = 2'd2;

    // Fixed field widths of the channels
    localparam int KEY_FIELD_W = 16;
    localparam int TAG_FIELD_W = 16;
    localparam int IDX_FIELD_W = 6;
    localparam int FILL_FIELD_W = 7;

    typedef struct packed {
        logic [1:0]             action;
        logic [KEY_FIELD_W-1:0] key;
        logic [TAG_FIELD_W-1:0] tag;
        logic [IDX_FIELD_W-1:0] index;
    } cmd_t;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0]  position;
        logic [KEY_FIELD_W-1:0]  read_key;
        logic [TAG_FIELD_W-1:0]  read_tag;
        logic [FILL_FIELD_W-1:0] fill;
        logic [1:0]              status;
    } rsp_t;

    // Per-cell control: insert strobe and where the cell sits against the fill count
    typedef struct packed {
        logic insert;
        logic occupied;
        logic at_end;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/sit_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One cell of the sorted insert table: holds a key and tag pair, compares it
// with the key being inserted and shifts from its lower neighbor. Uses sit_pkg.

module sit_cell #(
    parameter int KEY_W = 16,
    parameter int TAG_W = 16
) (
    input  wire                 clk,
    input  sit_pkg::cell_ctl_t  ctl,
    input  wire [KEY_W-1:0]     new_key,
    input  wire [TAG_W-1:0]     new_tag,
    input  wire [KEY_W-1:0]     left_key,
    input  wire [TAG_W-1:0]     left_tag,
    input  wire                 left_gt,
    output logic [KEY_W-1:0]    key,
    output logic [TAG_W-1:0]    tag,
    output logic                gt,
    output logic                took_new
);

    logic [KEY_W-1:0] key_reg, key_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic             moves;

    // Flag a stored entry that must move above the new pair
    assign gt = ctl.occupied && (key_reg > new_key);

    // The cell changes if it moves up or is the first free slot
    assign moves    = gt || ctl.at_end;
    assign took_new = moves && !left_gt;

    // Take the lower neighbor while it shifts, else the new pair at the slot
    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctl.insert && moves)
        begin
            if (left_gt)
            begin
                key_next = left_key;
                tag_next = left_tag;
            end
            else
            begin
                key_next = new_key;
                tag_next = new_tag;
            end
        end
    end

    // Hold the pair
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

`default_nettype wire

>>> rtl/core/sorted_insert_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sorted insert table, top level: a row of sit_cell instances, the fill count,
// position encoder, read select and the response register. Uses sit_pkg.
//
// The table keeps up to TABLE_DEPTH key and tag pairs in ascending key order in a
// row of cells; an insert lands after every entry with an equal or smaller key.
// Every cell compares its own key with the incoming one and shifts from its
// neighbor in the same cycle, so the block takes one command transaction (insert,
// read or clear) per cycle; a held response stalls the command side only while
// it is not taken. The response is registered and appears in the cycle after
// the command is accepted. Inserts into a full table are dropped with status
// full; reads at or beyond the fill count return zero with status out of range.
// Cell contents are not reset; only the count and the response valid are.

module sorted_insert_table_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 16,
    parameter int TAG_BITS    = 16
) (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           cmd_valid,
    output logic          cmd_stall,
    input  sit_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  wire           rsp_stall,
    output sit_pkg::rsp_t rsp
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W = $clog2(TABLE_DEPTH);
    localparam int RD_N  = (TABLE_DEPTH < 64) ? TABLE_DEPTH : 64;
    localparam int CMP_W = (CNT_W > sit_pkg::IDX_FIELD_W) ? CNT_W : sit_pkg::IDX_FIELD_W;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic                rsp_valid_reg, rsp_valid_next;
    sit_pkg::rsp_t       rsp_reg, rsp_next;

    logic                accept;
    logic                full;
    logic                insert_en;
    logic                read_ok;
    logic [KEY_BITS-1:0] new_key;
    logic [TAG_BITS-1:0] new_tag;

    logic [KEY_BITS-1:0] cell_key [TABLE_DEPTH];
    logic [TAG_BITS-1:0] cell_tag [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_gt;
    logic [TABLE_DEPTH-1:0] cell_took;
    logic [POS_W-1:0]    slot;

    logic [sit_pkg::KEY_FIELD_W-1:0] rd_key [64];
    logic [sit_pkg::TAG_FIELD_W-1:0] rd_tag [64];

    // Handshake: stall only while a response is held
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;

    assign new_key   = KEY_BITS'(cmd.key);
    assign new_tag   = TAG_BITS'(cmd.tag);
    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign insert_en = accept && (cmd.action == sit_pkg::ACT_INSERT) && !full;
    assign read_ok   = CMP_W'(cmd.index) < CMP_W'(count_reg);

    // Row of cells
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            sit_pkg::cell_ctl_t ctl;
            logic [KEY_BITS-1:0] lk;
            logic [TAG_BITS-1:0] lt;
            logic                lg;

            assign ctl.insert   = insert_en;
            assign ctl.occupied = CNT_W'(g) < count_reg;
            assign ctl.at_end   = CNT_W'(g) == count_reg;

            if (g == 0)
            begin : g_first
                assign lk = '0;
                assign lt = '0;
                assign lg = 1'b0;
            end
            else
            begin : g_rest
                assign lk = cell_key[g-1];
                assign lt = cell_tag[g-1];
                assign lg = cell_gt[g-1];
            end

            sit_cell #(
                .KEY_W (KEY_BITS),
                .TAG_W (TAG_BITS)
            ) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .new_key  (new_key),
                .new_tag  (new_tag),
                .left_key (lk),
                .left_tag (lt),
                .left_gt  (lg),
                .key      (cell_key[g]),
                .tag      (cell_tag[g]),
                .gt       (cell_gt[g]),
                .took_new (cell_took[g])
            );
        end

        // Read candidates: cells reachable by the index field, zero beyond depth
        for (g = 0; g < 64; g++)
        begin : g_rd
            if (g < RD_N)
            begin : g_live
                assign rd_key[g] = sit_pkg::KEY_FIELD_W'(cell_key[g]);
                assign rd_tag[g] = sit_pkg::TAG_FIELD_W'(cell_tag[g]);
            end
            else
            begin : g_none
                assign rd_key[g] = '0;
                assign rd_tag[g] = '0;
            end
        end
    endgenerate

    // Encode the one-hot slot flag into a position
    always_comb
    begin
        slot = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (cell_took[i])
            begin
                slot = slot | POS_W'(i);
            end
        end
    end

    // Next count and response
    always_comb
    begin
        count_next = count_reg;
        rsp_next   = rsp_reg;
        if (accept)
        begin
            rsp_next.position = '0;
            rsp_next.read_key = '0;
            rsp_next.read_tag = '0;
            rsp_next.status   = sit_pkg::ST_OK;
            unique case (cmd.action)
                sit_pkg::ACT_INSERT:
                begin
                    if (full)
                    begin
                        rsp_next.status = sit_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next        = count_reg + CNT_W'(1);
                        rsp_next.position = sit_pkg::IDX_FIELD_W'(slot);
                    end
                end
                sit_pkg::ACT_READ:
                begin
                    if (read_ok)
                    begin
                        rsp_next.read_key = rd_key[cmd.index];
                        rsp_next.read_tag = rd_tag[cmd.index];
                    end
                    else
                    begin
                        rsp_next.status = sit_pkg::ST_RANGE_ERR;
                    end
                end
                sit_pkg::ACT_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
            rsp_next.fill = sit_pkg::FILL_FIELD_W'(count_next);
        end
    end

    // Advance the response valid: set on accept, drop when taken
    always_comb
    begin
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload register
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
